// File: rtl/pci_pkg.sv
// Package with the stage types and fixed-point cut tables of the photon classifier.
package pci_pkg;

  localparam int NUM_LVL = 3;
  localparam int LVL_LOOSE = 0;
  localparam int LVL_MEDIUM = 1;
  localparam int LVL_TIGHT = 2;

  localparam int REG_BARREL = 0;
  localparam int REG_ENDCAP = 1;

  // Width of every isolation limit: iso values sit 40 bits up, sums stay below 2^61.
  localparam int LIM_W = 61;

  // Helpers that turn decimal table entries into fixed point at elaboration time.
  function automatic logic [63:0] ceil_hoe(input logic [63:0] x);
    return ((x << 16) + 64'd99999) / 64'd100000;
  endfunction

  function automatic logic [63:0] ceil_sie(input logic [63:0] x);
    return ((x << 20) + 64'd99999) / 64'd100000;
  endfunction

  function automatic logic [63:0] rnd_milli_e(input logic [63:0] x);
    return (((x * 64'd64) << 40) + 64'd500) / 64'd1000;
  endfunction

  function automatic logic [63:0] rnd_micro(input logic [63:0] x);
    return ((x << 40) + 64'd500000) / 64'd1000000;
  endfunction

  function automatic logic [63:0] rnd_e8(input logic [63:0] x);
    return ((x << 34) + 64'd50000000) / 64'd100000000;
  endfunction

  localparam logic [13:0] ETA_SPLIT = 14'(((64'd1479 << 12) + 64'd999) / 64'd1000);
  localparam logic [13:0] ETA_MAX = 14'(((64'd25 << 12) + 64'd9) / 64'd10);

  // Tables are [region][level].
  localparam logic [19:0] HOE_TAB [2][NUM_LVL] = '{
    '{20'(ceil_hoe(64'd4596)), 20'(ceil_hoe(64'd2197)), 20'(ceil_hoe(64'd2148))},
    '{20'(ceil_hoe(64'd5900)), 20'(ceil_hoe(64'd3260)), 20'(ceil_hoe(64'd3210))}
  };

  localparam logic [15:0] SIE_TAB [2][NUM_LVL] = '{
    '{16'(ceil_sie(64'd1060)), 16'(ceil_sie(64'd1015)), 16'(ceil_sie(64'd996))},
    '{16'(ceil_sie(64'd2720)), 16'(ceil_sie(64'd2720)), 16'(ceil_sie(64'd2710))}
  };

  localparam logic [LIM_W-1:0] CH1_TAB [2][NUM_LVL] = '{
    '{LIM_W'(rnd_milli_e(64'd1694)), LIM_W'(rnd_milli_e(64'd1141)),
      LIM_W'(rnd_milli_e(64'd650))},
    '{LIM_W'(rnd_milli_e(64'd2089)), LIM_W'(rnd_milli_e(64'd1051)),
      LIM_W'(rnd_milli_e(64'd517))}
  };

  localparam logic [LIM_W-1:0] NH1_TAB [2][NUM_LVL] = '{
    '{LIM_W'(rnd_milli_e(64'd24032)), LIM_W'(rnd_milli_e(64'd1189)),
      LIM_W'(rnd_milli_e(64'd317))},
    '{LIM_W'(rnd_milli_e(64'd19722)), LIM_W'(rnd_milli_e(64'd2718)),
      LIM_W'(rnd_milli_e(64'd2716))}
  };

  localparam logic [LIM_W-1:0] PH1_TAB [2][NUM_LVL] = '{
    '{LIM_W'(rnd_milli_e(64'd2876)), LIM_W'(rnd_milli_e(64'd2080)),
      LIM_W'(rnd_milli_e(64'd2044))},
    '{LIM_W'(rnd_milli_e(64'd4162)), LIM_W'(rnd_milli_e(64'd3867)),
      LIM_W'(rnd_milli_e(64'd3032))}
  };

  // Et slopes and the Et-squared coefficient depend on the region only.
  localparam logic [33:0] NH2_TAB [2] = '{34'(rnd_micro(64'd15120)), 34'(rnd_micro(64'd11700))};
  localparam logic [33:0] PH2_TAB [2] = '{34'(rnd_micro(64'd4017)), 34'(rnd_micro(64'd3700))};
  localparam logic [18:0] NH3_TAB [2] = '{19'(rnd_e8(64'd2259)), 19'(rnd_e8(64'd2300))};

  typedef struct packed {
    logic               region;
    logic [NUM_LVL-1:0] ok;
    logic [39:0]        et_sq;
    logic [28:0]        ach_rho;
    logic [28:0]        anh_rho;
    logic [28:0]        aph_rho;
    logic [53:0]        nh2_et;
    logic [53:0]        ph2_et;
    logic [19:0]        chi;
    logic [19:0]        nhi;
    logic [19:0]        phi;
  } s1_t;

  typedef struct packed {
    logic               region;
    logic [NUM_LVL-1:0] ok;
    logic [38:0]        p_lo;
    logic [38:0]        p_hi;
    logic [54:0]        nhs;
    logic [54:0]        phs;
    logic [19:0]        nhi;
    logic [19:0]        phi;
  } s2_t;

  typedef struct packed {
    logic               region;
    logic [NUM_LVL-1:0] ok;
    logic [59:0]        nhs;
    logic [19:0]        nhi;
  } s3_t;

endpackage

// File: rtl/photon_cut_id_classifier.sv
// Top level of the cut-based photon identification pipeline.
// This block takes one photon candidate per request and returns one result per request: the
// loose, medium and tight pass flags and the barrel or endcap region. It accepts a new
// request in every clock cycle while the receiver keeps taking results, and results leave
// in order. The four register stages are set by the multipliers: the first stage forms et
// squared, the Et slope products and the area times rho products, the second splits the
// neutral hadron et-squared term into two partial products and checks charged isolation,
// the third sums those and checks photon isolation, and the fourth checks neutral
// isolation into the output register. Each stage holds its request while the next one is
// full, so a stalled result does not stop upstream stages that still have room.
//
// A candidate with |eta| of 2.5 or more fails every level but still reports the endcap
// region. Every isolation cut is a strict less-than against a constant plus effective area
// times rho, plus Et terms for neutral and photon; exact fixed point, no run-time rounding.
module photon_cut_id_classifier import pci_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [19:0] et,
  input  logic [13:0] abs_sc_eta,
  input  logic [19:0] h_over_e,
  input  logic [15:0] sigma_ieta_ieta,
  input  logic [19:0] charged_iso,
  input  logic [19:0] neutral_iso,
  input  logic [19:0] photon_iso_sum,
  input  logic [12:0] rho,
  input  logic [15:0] area_charged,
  input  logic [15:0] area_neutral,
  input  logic [15:0] area_photon,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        pass_loose,
  output logic        pass_medium,
  output logic        pass_tight,
  output logic        is_endcap
);

  // Stage one to stage two handshake and payload.
  logic s1_valid;
  logic s1_ready;
  s1_t  s1;

  // Stage three to output stage handshake and payload.
  logic s3_valid;
  logic s3_ready;
  s3_t  s3;

  pci_prod u_prod (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .et              (et),
    .abs_sc_eta      (abs_sc_eta),
    .h_over_e        (h_over_e),
    .sigma_ieta_ieta (sigma_ieta_ieta),
    .charged_iso     (charged_iso),
    .neutral_iso     (neutral_iso),
    .photon_iso_sum  (photon_iso_sum),
    .rho             (rho),
    .area_charged    (area_charged),
    .area_neutral    (area_neutral),
    .area_photon     (area_photon),
    .s1_valid        (s1_valid),
    .s1_ready        (s1_ready),
    .s1              (s1)
  );

  pci_limit u_limit (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1),
    .s3_valid (s3_valid),
    .s3_ready (s3_ready),
    .s3       (s3)
  );

  pci_decide u_decide (
    .clk         (clk),
    .rst         (rst),
    .s3_valid    (s3_valid),
    .s3_ready    (s3_ready),
    .s3          (s3),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pass_loose  (pass_loose),
    .pass_medium (pass_medium),
    .pass_tight  (pass_tight),
    .is_endcap   (is_endcap)
  );

endmodule

// File: rtl/pci_prod.sv
// First stage: region, acceptance, H/E and width cuts, and the input products.
module pci_prod import pci_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [19:0] et,
  input  logic [13:0] abs_sc_eta,
  input  logic [19:0] h_over_e,
  input  logic [15:0] sigma_ieta_ieta,
  input  logic [19:0] charged_iso,
  input  logic [19:0] neutral_iso,
  input  logic [19:0] photon_iso_sum,
  input  logic [12:0] rho,
  input  logic [15:0] area_charged,
  input  logic [15:0] area_neutral,
  input  logic [15:0] area_photon,
  output logic        s1_valid,
  input  logic        s1_ready,
  output s1_t         s1
);

  logic en;
  logic in_acc;
  s1_t  s1_next;

  assign en = !s1_valid || s1_ready;
  assign in_ready = en;
  assign in_acc = abs_sc_eta < ETA_MAX;

  always_comb begin
    s1_next.region = (abs_sc_eta >= ETA_SPLIT);
    for (int l = 0; l < NUM_LVL; l++) begin
      s1_next.ok[l] = in_acc && (h_over_e < HOE_TAB[s1_next.region][l]) &&
                      (sigma_ieta_ieta < SIE_TAB[s1_next.region][l]);
    end
    s1_next.et_sq   = 40'(et) * 40'(et);
    s1_next.ach_rho = 29'(area_charged) * 29'(rho);
    s1_next.anh_rho = 29'(area_neutral) * 29'(rho);
    s1_next.aph_rho = 29'(area_photon) * 29'(rho);
    s1_next.nh2_et  = 54'(NH2_TAB[s1_next.region]) * 54'(et);
    s1_next.ph2_et  = 54'(PH2_TAB[s1_next.region]) * 54'(et);
    s1_next.chi     = charged_iso;
    s1_next.nhi     = neutral_iso;
    s1_next.phi     = photon_iso_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      s1 <= s1_next;
    end
  end

endmodule

// File: rtl/pci_limit.sv
// Second and third stages: charged and photon isolation cuts, neutral limit build-up.
module pci_limit import pci_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s1_valid,
  output logic s1_ready,
  input  s1_t  s1,
  output logic s3_valid,
  input  logic s3_ready,
  output s3_t  s3
);

  logic        s2_valid;
  s2_t         s2;
  s2_t         s2_next;
  s3_t         s3_next;
  logic        en2;
  logic        en3;
  logic [58:0] nh3_term;

  assign en3 = !s3_valid || s3_ready;
  assign en2 = !s2_valid || en3;
  assign s1_ready = en2;

  // The Et-squared term is split into two 19x20 partial products here.
  always_comb begin
    s2_next.region = s1.region;
    for (int l = 0; l < NUM_LVL; l++) begin
      s2_next.ok[l] = s1.ok[l] && (LIM_W'({s1.chi, 40'b0}) <
                      (CH1_TAB[s1.region][l] + LIM_W'({s1.ach_rho, 24'b0})));
    end
    s2_next.p_lo = 39'(NH3_TAB[s1.region]) * 39'(s1.et_sq[19:0]);
    s2_next.p_hi = 39'(NH3_TAB[s1.region]) * 39'(s1.et_sq[39:20]);
    s2_next.nhs  = 55'({s1.anh_rho, 24'b0}) + 55'(s1.nh2_et);
    s2_next.phs  = 55'({s1.aph_rho, 24'b0}) + 55'(s1.ph2_et);
    s2_next.nhi  = s1.nhi;
    s2_next.phi  = s1.phi;
  end

  always_comb begin
    nh3_term = 59'(s2.p_lo) + {s2.p_hi, 20'b0};
    s3_next.region = s2.region;
    for (int l = 0; l < NUM_LVL; l++) begin
      s3_next.ok[l] = s2.ok[l] && (LIM_W'({s2.phi, 40'b0}) <
                      (PH1_TAB[s2.region][l] + LIM_W'(s2.phs)));
    end
    s3_next.nhs = 60'(s2.nhs) + 60'(nh3_term);
    s3_next.nhi = s2.nhi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (en2) begin
        s2_valid <= s1_valid;
      end
      if (en3) begin
        s3_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_valid) begin
      s2 <= s2_next;
    end
    if (en3 && s2_valid) begin
      s3 <= s3_next;
    end
  end

endmodule

// File: rtl/pci_decide.sv
// Last stage: neutral hadron isolation cut and the registered result.
module pci_decide import pci_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s3_valid,
  output logic s3_ready,
  input  s3_t  s3,
  output logic out_valid,
  input  logic out_ready,
  output logic pass_loose,
  output logic pass_medium,
  output logic pass_tight,
  output logic is_endcap
);

  logic               en;
  logic [NUM_LVL-1:0] pass_next;

  assign en = !out_valid || out_ready;
  assign s3_ready = en;

  always_comb begin
    for (int l = 0; l < NUM_LVL; l++) begin
      pass_next[l] = s3.ok[l] && (LIM_W'({s3.nhi, 40'b0}) <
                     (NH1_TAB[s3.region][l] + LIM_W'(s3.nhs)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s3_valid) begin
      pass_loose  <= pass_next[LVL_LOOSE];
      pass_medium <= pass_next[LVL_MEDIUM];
      pass_tight  <= pass_next[LVL_TIGHT];
      is_endcap   <= (s3.region == 1'(REG_ENDCAP));
    end
  end

endmodule

// File: bench/photon_cut_id_classifier_tb.sv
// Self-checking testbench for the cut-based photon identification pipeline.
`timescale 1ns / 1ps

module photon_cut_id_classifier_tb;
  import pci_pkg::*;

  // 64-bit working type for the fixed-point cut arithmetic. Every limit fits well below 2^61.
  typedef bit [63:0] fx_t;

  // One working point after scaling to fixed point.
  typedef struct {
    fx_t hoe;
    fx_t sie;
    fx_t ch1;
    fx_t nh1;
    fx_t nh2;
    fx_t nh3;
    fx_t ph1;
    fx_t ph2;
  } cut_t;

  // One photon candidate, in the order of the block's input ports.
  typedef struct packed {
    logic [19:0] et;
    logic [13:0] abs_sc_eta;
    logic [19:0] h_over_e;
    logic [15:0] sigma_ieta_ieta;
    logic [19:0] charged_iso;
    logic [19:0] neutral_iso;
    logic [19:0] photon_iso_sum;
    logic [12:0] rho;
    logic [15:0] area_charged;
    logic [15:0] area_neutral;
    logic [15:0] area_photon;
  } photon_t;

  // The four flags that come back for each candidate.
  typedef struct packed {
    logic loose;
    logic med;
    logic tight;
    logic endcap;
  } verdict_t;

  // Cycles without any handshake before the run is declared hung. The longest legitimate
  // quiet stretch is the deliberate receiver hold-off, so this leaves a wide margin.
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  // Cycles to keep watching after the last expected result, to catch stray extra results.
  localparam int TAIL_CYCLES = 12;

  // Decimal cut tables, [region][level]. Shape cuts are in units of 1e-5, constant isolation
  // terms in MeV, the Et slopes in 1e-6 and the Et-squared coefficient in 1e-8.
  localparam int HOE_E5 [2][3] = '{'{4596, 2197, 2148}, '{5900, 3260, 3210}};
  localparam int SIE_E5 [2][3] = '{'{1060, 1015, 996}, '{2720, 2720, 2710}};
  localparam int CH1_MEV [2][3] = '{'{1694, 1141, 650}, '{2089, 1051, 517}};
  localparam int NH1_MEV [2][3] = '{'{24032, 1189, 317}, '{19722, 2718, 2716}};
  localparam int PH1_MEV [2][3] = '{'{2876, 2080, 2044}, '{4162, 3867, 3032}};
  localparam int NH2_E6 [2] = '{15120, 11700};
  localparam int NH3_E8 [2] = '{2259, 2300};
  localparam int PH2_E6 [2] = '{4017, 3700};

  // Scale num/den by 2^sh, rounding up (shape and eta cuts) or to nearest (isolation terms).
  function automatic fx_t ceil_scaled(fx_t num, fx_t den, int sh);
    return ((num << sh) + den - 1) / den;
  endfunction

  function automatic fx_t round_scaled(fx_t num, fx_t den, int sh);
    return ((num << sh) + den / 2) / den;
  endfunction

  // Barrel/endcap split at |eta| 1.479 and acceptance edge at 2.5, in units of 2^-12.
  localparam int ETA_SPLIT_Q = int'(ceil_scaled(64'd1479, 64'd1000, 12));
  localparam int ETA_EDGE_Q = int'(ceil_scaled(64'd25, 64'd10, 12));

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [19:0] et;
  logic [13:0] abs_sc_eta;
  logic [19:0] h_over_e;
  logic [15:0] sigma_ieta_ieta;
  logic [19:0] charged_iso;
  logic [19:0] neutral_iso;
  logic [19:0] photon_iso_sum;
  logic [12:0] rho;
  logic [15:0] area_charged;
  logic [15:0] area_neutral;
  logic [15:0] area_photon;
  logic        out_valid;
  logic        out_ready;
  logic        pass_loose;
  logic        pass_medium;
  logic        pass_tight;
  logic        is_endcap;

  // Verdicts predicted for accepted requests, oldest first.
  verdict_t verdicts_due[$];
  int       mismatches = 0;
  int       stall_cycles = 0;
  // The test sequence turns random idling on and off per phase on each side.
  bit       tx_gaps = 1'b0;
  bit       rx_gaps = 1'b0;
  // A long receiver hold-off is asked for by bumping hold_asks; the receiver serves it.
  int       hold_asks = 0;
  int       holds_served = 0;

  photon_cut_id_classifier u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .et              (et),
    .abs_sc_eta      (abs_sc_eta),
    .h_over_e        (h_over_e),
    .sigma_ieta_ieta (sigma_ieta_ieta),
    .charged_iso     (charged_iso),
    .neutral_iso     (neutral_iso),
    .photon_iso_sum  (photon_iso_sum),
    .rho             (rho),
    .area_charged    (area_charged),
    .area_neutral    (area_neutral),
    .area_photon     (area_photon),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .pass_loose      (pass_loose),
    .pass_medium     (pass_medium),
    .pass_tight      (pass_tight),
    .is_endcap       (is_endcap)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Builds one working point in fixed point. Constant isolation terms are MeV times 64,
  // giving 1/64 GeV, then lifted to 2^-40 of that unit. The Et-squared coefficient is
  // lifted by 34 bits only, since et*et carries an extra factor of 64.
  function automatic cut_t wp_cut(int region, int lvl);
    cut_t k;
    k.hoe = ceil_scaled(fx_t'(HOE_E5[region][lvl]), 64'd100000, 16);
    k.sie = ceil_scaled(fx_t'(SIE_E5[region][lvl]), 64'd100000, 20);
    k.ch1 = round_scaled(fx_t'(CH1_MEV[region][lvl]) * 64, 64'd1000, 40);
    k.nh1 = round_scaled(fx_t'(NH1_MEV[region][lvl]) * 64, 64'd1000, 40);
    k.ph1 = round_scaled(fx_t'(PH1_MEV[region][lvl]) * 64, 64'd1000, 40);
    k.nh2 = round_scaled(fx_t'(NH2_E6[region]), 64'd1000000, 40);
    k.nh3 = round_scaled(fx_t'(NH3_E8[region]), 64'd100000000, 34);
    k.ph2 = round_scaled(fx_t'(PH2_E6[region]), 64'd1000000, 40);
    return k;
  endfunction

  // Isolation limits of one working point for one candidate, in units of 2^-40 of 1/64 GeV.
  // Area times rho is in 2^-16 of the energy unit, hence the shift by 24.
  function automatic void iso_limits(cut_t k, photon_t p, output fx_t ch, output fx_t nh,
                                     output fx_t ph);
    fx_t e;
    fx_t r;
    e = fx_t'(p.et);
    r = fx_t'(p.rho);
    ch = k.ch1 + ((fx_t'(p.area_charged) * r) << 24);
    nh = k.nh1 + ((fx_t'(p.area_neutral) * r) << 24) + k.nh2 * e + k.nh3 * (e * e);
    ph = k.ph1 + ((fx_t'(p.area_photon) * r) << 24) + k.ph2 * e;
  endfunction

  // Smallest isolation value, in 1/64 GeV, that no longer passes the given limit.
  function automatic fx_t iso_edge(fx_t lim);
    return (lim + (fx_t'(1) << 40) - 1) >> 40;
  endfunction

  // Expected flags for one candidate. All cuts are strict less-than, and a candidate
  // outside the acceptance fails every level while still reporting the endcap region.
  function automatic verdict_t classify_photon(photon_t p);
    verdict_t v;
    cut_t     k;
    fx_t      ch;
    fx_t      nh;
    fx_t      ph;
    int       region;
    bit       in_acc;
    bit [NUM_LVL-1:0] ok;
    region = (int'(p.abs_sc_eta) < ETA_SPLIT_Q) ? REG_BARREL : REG_ENDCAP;
    in_acc = int'(p.abs_sc_eta) < ETA_EDGE_Q;
    for (int lvl = 0; lvl < NUM_LVL; lvl++) begin
      k = wp_cut(region, lvl);
      iso_limits(k, p, ch, nh, ph);
      ok[lvl] = in_acc && (fx_t'(p.h_over_e) < k.hoe) && (fx_t'(p.sigma_ieta_ieta) < k.sie)
                && ((fx_t'(p.charged_iso) << 40) < ch)
                && ((fx_t'(p.neutral_iso) << 40) < nh)
                && ((fx_t'(p.photon_iso_sum) << 40) < ph);
    end
    v.loose = ok[LVL_LOOSE];
    v.med = ok[LVL_MEDIUM];
    v.tight = ok[LVL_TIGHT];
    v.endcap = (region == REG_ENDCAP);
    return v;
  endfunction

  // Picks a value relative to a cut edge: often right at the edge, mostly comfortably
  // below it, and sometimes anywhere in the field's range.
  function automatic fx_t near_cut(fx_t lim, fx_t top);
    fx_t v;
    fx_t hi;
    int  mode;
    mode = $urandom_range(0, 5);
    if (mode < 2) begin
      v = lim + $urandom_range(0, 3);
      v = (v >= 2) ? v - 2 : 0;
    end else if (mode < 5) begin
      hi = (lim == 0) ? 0 : lim - 1;
      if (hi > top) hi = top;
      v = $urandom_range(0, 32'(hi));
    end else begin
      v = $urandom_range(0, 32'(top));
    end
    if (v > top) v = top;
    return v;
  endfunction

  // Length of an idle stretch on either side: mostly none, else short, now and then long.
  function automatic int idle_len();
    if ($urandom_range(0, 2) != 0) return 0;
    return ($urandom_range(0, 15) == 0) ? $urandom_range(16, 48) : $urandom_range(1, 3);
  endfunction

  // Random candidate. Most are aimed at the cut edges of one randomly chosen working point
  // so that pass and fail both show up at every level; the rest are raw noise over all bits.
  function automatic photon_t random_photon();
    photon_t    p;
    cut_t       k;
    fx_t        ch;
    fx_t        nh;
    fx_t        ph;
    bit [191:0] raw;
    int         want_endcap;
    int         lvl;
    if ($urandom_range(0, 6) == 0) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      p = raw[190:0];
      return p;
    end
    want_endcap = $urandom_range(0, 1);
    lvl = $urandom_range(0, NUM_LVL - 1);
    case ($urandom_range(0, 9))
      0: p.abs_sc_eta = 14'($urandom_range(ETA_EDGE_Q, 16383));
      1: p.abs_sc_eta = 14'(ETA_SPLIT_Q - 1 + $urandom_range(0, 1));
      2: p.abs_sc_eta = 14'(ETA_EDGE_Q - 1 + $urandom_range(0, 1));
      default: begin
        if (want_endcap != 0) p.abs_sc_eta = 14'($urandom_range(ETA_SPLIT_Q, ETA_EDGE_Q - 1));
        else p.abs_sc_eta = 14'($urandom_range(0, ETA_SPLIT_Q - 1));
      end
    endcase
    // Mostly physical energies below 128 GeV, with an occasional one over the full range.
    p.et = ($urandom_range(0, 7) == 0) ? 20'($urandom) : 20'($urandom_range(0, 8191));
    p.rho = 13'($urandom);
    p.area_charged = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16383));
    p.area_neutral = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16383));
    p.area_photon = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16383));
    k = wp_cut((int'(p.abs_sc_eta) < ETA_SPLIT_Q) ? REG_BARREL : REG_ENDCAP, lvl);
    p.h_over_e = 20'(near_cut(k.hoe, 64'hFFFFF));
    p.sigma_ieta_ieta = 16'(near_cut(k.sie, 64'hFFFF));
    iso_limits(k, p, ch, nh, ph);
    p.charged_iso = 20'(near_cut(iso_edge(ch), 64'hFFFFF));
    p.neutral_iso = 20'(near_cut(iso_edge(nh), 64'hFFFFF));
    p.photon_iso_sum = 20'(near_cut(iso_edge(ph), 64'hFFFFF));
    return p;
  endfunction

  // Offers one request after an optional idle gap and returns once it has been accepted.
  // Valid stays high between back-to-back requests; it drops during a gap and while the
  // sender waits for a drain.
  task automatic send_photon(photon_t p);
    int gap;
    gap = tx_gaps ? idle_len() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    {et, abs_sc_eta, h_over_e, sigma_ieta_ieta, charged_iso, neutral_iso, photon_iso_sum,
     rho, area_charged, area_neutral, area_photon} <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering requests and waits until every predicted result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  // Extremes of every field, both sides of the region split and the acceptance edge, and a
  // cut of each shape and isolation kind just below and exactly at its limit.
  task automatic test_directed_edges();
    photon_t base;
    photon_t p;
    cut_t    k;
    fx_t     ch;
    fx_t     nh;
    fx_t     ph;
    int      eta_pts[5];
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    base = '0;
    send_photon(base);
    p = '1;
    send_photon(p);
    // Region split and acceptance edge; past 2.5 everything fails but the region says endcap.
    eta_pts = '{ETA_SPLIT_Q - 1, ETA_SPLIT_Q, ETA_EDGE_Q - 1, ETA_EDGE_Q, 16383};
    foreach (eta_pts[i]) begin
      p = base;
      p.abs_sc_eta = 14'(eta_pts[i]);
      send_photon(p);
    end
    // H/E right at the barrel tight limit, then at the endcap loose limit.
    k = wp_cut(REG_BARREL, LVL_TIGHT);
    p = base;
    p.h_over_e = 20'(k.hoe - 1);
    send_photon(p);
    p.h_over_e = 20'(k.hoe);
    send_photon(p);
    k = wp_cut(REG_ENDCAP, LVL_LOOSE);
    p = base;
    p.abs_sc_eta = 14'(ETA_SPLIT_Q);
    p.h_over_e = 20'(k.hoe - 1);
    send_photon(p);
    p.h_over_e = 20'(k.hoe);
    send_photon(p);
    k = wp_cut(REG_BARREL, LVL_MEDIUM);
    p = base;
    p.sigma_ieta_ieta = 16'(k.sie - 1);
    send_photon(p);
    p.sigma_ieta_ieta = 16'(k.sie);
    send_photon(p);
    // Isolation edges with the largest Et, rho and areas, so every term of the sums counts.
    p = base;
    p.et = '1;
    p.rho = '1;
    p.area_charged = '1;
    p.area_neutral = '1;
    p.area_photon = '1;
    base = p;
    k = wp_cut(REG_BARREL, LVL_TIGHT);
    iso_limits(k, base, ch, nh, ph);
    p = base;
    p.charged_iso = 20'(iso_edge(ch) - 1);
    send_photon(p);
    p.charged_iso = 20'(iso_edge(ch));
    send_photon(p);
    p = base;
    p.neutral_iso = 20'(iso_edge(nh) - 1);
    send_photon(p);
    p.neutral_iso = 20'(iso_edge(nh));
    send_photon(p);
    p = base;
    p.photon_iso_sum = 20'(iso_edge(ph) - 1);
    send_photon(p);
    p.photon_iso_sum = 20'(iso_edge(ph));
    send_photon(p);
    k = wp_cut(REG_ENDCAP, LVL_TIGHT);
    base.abs_sc_eta = 14'(ETA_EDGE_Q - 1);
    iso_limits(k, base, ch, nh, ph);
    p = base;
    p.neutral_iso = 20'(iso_edge(nh) - 1);
    send_photon(p);
    p.neutral_iso = 20'(iso_edge(nh));
    send_photon(p);
  endtask

  // Full rate on both sides: one request and one result every cycle.
  task automatic test_back_to_back(int count);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    repeat (count) send_photon(random_photon());
  endtask

  // The receiver stops for a long stretch while requests keep coming, so the pipeline
  // fills and must push back on its input without losing or reordering anything.
  task automatic test_output_backpressure(int count);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    hold_asks++;
    repeat (count) send_photon(random_photon());
  endtask

  // Random idling on both sides over the bulk of the random stimulus.
  task automatic test_random_stream(int count);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    repeat (count) send_photon(random_photon());
  endtask

  // Bursts separated by full drains, so the pipeline restarts from empty each time.
  task automatic test_drain_pause(int bursts, int count);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    repeat (bursts) begin
      repeat (count) send_photon(random_photon());
      wait_drained();
    end
  endtask

  // Receiver side: drives out_ready once per falling edge, serving long hold-offs first.
  initial begin : result_taker
    int gap_left;
    int hold_left;
    out_ready = 1'b0;
    gap_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_asks != holds_served) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ready <= 1'b0;
      end else begin
        gap_left = rx_gaps ? idle_len() : 0;
        if (gap_left > 0) begin
          gap_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  function automatic void check_flag(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, actual %0b", name, want, got);
      mismatches++;
    end
  endfunction

  // Scoreboard. Both handshakes are sampled at the rising edge, where the block's registers
  // still hold their old values; the prediction is queued before the result check so the
  // order inside one edge cannot matter.
  always @(posedge clk) begin : result_check
    verdict_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        verdicts_due.insert(verdicts_due.size(),
                            classify_photon({et, abs_sc_eta, h_over_e, sigma_ieta_ieta,
                                             charged_iso, neutral_iso, photon_iso_sum,
                                             rho, area_charged, area_neutral,
                                             area_photon}));
      end
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $error("result accepted with no request outstanding");
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          check_flag("pass_loose", want.loose, pass_loose);
          check_flag("pass_medium", want.med, pass_medium);
          check_flag("pass_tight", want.tight, pass_tight);
          check_flag("is_endcap", want.endcap, is_endcap);
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no handshake on either side means the block hung.
  always @(posedge clk) begin : hang_watch
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    {et, abs_sc_eta, h_over_e, sigma_ieta_ieta, charged_iso, neutral_iso, photon_iso_sum,
     rho, area_charged, area_neutral, area_photon} = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_back_to_back(150);
    test_output_backpressure(60);
    test_random_stream(1100);
    test_drain_pause(3, 20);

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/pci_pkg.sv
rtl/pci_prod.sv
rtl/pci_limit.sv
rtl/pci_decide.sv
rtl/photon_cut_id_classifier.sv
bench/photon_cut_id_classifier_tb.sv
